// ===== rtl/qle_pkg.sv =====
// qle_pkg: shared types, command codes, register indexes and reset values
// for the tabular Q-learning engine. No dependencies.
`timescale 1ns / 1ps

package qle_pkg;

   localparam int DEF_MAX_STATES  = 64;
   localparam int DEF_MAX_ACTIONS = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_STATES_IN_USE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIONS_IN_USE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEARNING_RATE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISCOUNT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEARN_ENABLE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPLORE_LIMIT  = 3'd5;

   localparam logic [6:0]  RST_STATES_IN_USE  = 7'd64;
   localparam logic [3:0]  RST_ACTIONS_IN_USE = 4'd8;
   localparam logic [16:0] RST_LEARNING_RATE  = 17'd32768;
   localparam logic [15:0] RST_DISCOUNT       = 16'd58982;
   localparam logic        RST_LEARN_ENABLE   = 1'b1;
   localparam logic [15:0] RST_EXPLORE_LIMIT  = 16'd100;

   localparam logic [16:0] LEARNING_RATE_ONE = 17'h10000;
   localparam logic [15:0] LFSR_SEED         = 16'hACE1;

   typedef enum logic [1:0] {
      CMD_UPDATE     = 2'd0,
      CMD_GET_ACTION = 2'd1,
      CMD_LOAD       = 2'd2,
      CMD_RESERVED   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic [5:0]         cur_state;
      logic [5:0]         next_state;
      logic [2:0]         taken_action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] chosen_action;
      logic       status;
   } rsp_type;

   // effective configuration, already clamped to the legal ranges
   typedef struct packed {
      logic [6:0]  states;
      logic [3:0]  actions;
      logic [16:0] learn_rate;
      logic [15:0] discount;
      logic        learn_enable;
      logic [15:0] explore_limit;
   } cfg_type;

endpackage

// ===== rtl/qle_table.sv =====
// qle_table: Q value store, one write port and one read port with
// registered read data. Depends on nothing.
`timescale 1ns / 1ps

module qle_table #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [31:0]   wdata,
   input  logic [AW-1:0] raddr,
   output logic [31:0]   rdata
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/qle_mod.sv =====
// qle_mod: bit-serial remainder of a 16-bit value by a 4-bit divisor,
// one quotient bit per cycle. Depends on nothing.
`timescale 1ns / 1ps

module qle_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [3:0]  divisor,
   output logic        done,
   output logic [3:0]  remainder
);

   logic [15:0] shift_ff;
   logic [3:0]  rem_ff;
   logic [3:0]  count_ff;
   logic        run_ff;
   logic        done_ff;
   logic [4:0]  trial;

   assign trial = {rem_ff, shift_ff[15]};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= !start && run_ff && (count_ff == 4'd0);
         if (start) begin
            shift_ff <= dividend;
            rem_ff   <= '0;
            count_ff <= 4'd15;
            run_ff   <= 1'b1;
         end else if (run_ff) begin
            shift_ff <= {shift_ff[14:0], 1'b0};
            // remainder stays below the divisor, so one subtract suffices
            if (trial >= {1'b0, divisor}) begin
               rem_ff <= 4'(trial - {1'b0, divisor});
            end else begin
               rem_ff <= trial[3:0];
            end
            count_ff <= count_ff - 4'd1;
            if (count_ff == 4'd0) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/qle_engine.sv =====
// qle_engine: command sequencer and update datapath; scans table rows,
// runs the two-multiply update and writes back. Uses qle_pkg.
`timescale 1ns / 1ps

module qle_engine import qle_pkg::*; #(
   parameter int MAX_STATES  = DEF_MAX_STATES,
   parameter int MAX_ACTIONS = DEF_MAX_ACTIONS,
   parameter int DEPTH       = DEF_MAX_STATES * DEF_MAX_ACTIONS,
   parameter int AW          = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_type       req_item,
   input  cfg_type       cfg,
   output logic          busy,
   output logic          rsp_strobe,
   output rsp_type       rsp_item,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output logic [31:0]   mem_wdata,
   output logic [AW-1:0] mem_raddr,
   input  logic [31:0]   mem_rdata,
   output logic          mod_start,
   output logic [15:0]   mod_dividend,
   input  logic          mod_done,
   input  logic [3:0]    mod_remainder
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_DRAIN,
      S_MUL1,
      S_DIFF,
      S_MUL2,
      S_WB,
      S_RAND
   } state_type;

   state_type          state_ff;
   req_type            req_ff;
   rsp_type            rsp_ff;
   logic               strobe_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic [5:0]         row_ff;
   logic [3:0]         col_ff;
   logic [3:0]         rd_col_ff;
   logic               rd_vld_ff;
   logic [3:0]         last_col;
   logic signed [31:0] rd_data;
   logic signed [31:0] reward;
   logic               take;
   logic signed [31:0] best_val_ff;
   logic signed [31:0] best_val_in;
   logic [3:0]         best_idx_ff;
   logic [3:0]         best_idx_in;
   logic signed [31:0] q_ff;
   logic signed [48:0] disc_prod_ff;
   logic signed [33:0] diff_ff;
   logic signed [51:0] delta_prod_ff;
   logic signed [36:0] new_sum;
   logic [31:0]        new_val;
   logic [16:0]        explore_ff;
   logic [15:0]        lfsr_ff;
   logic [15:0]        lfsr_in;
   logic               lfsr_fb;
   logic               s_ok;
   logic               sp_ok;
   logic               a_ok;
   logic               explore_now;

   function automatic logic [AW-1:0] entry_addr(input logic [5:0] row,
                                                input logic [3:0] col);
      return AW'(32'(row) * MAX_ACTIONS + 32'(col));
   endfunction

   function automatic rsp_type make_rsp(input logic [2:0] act, input logic err);
      rsp_type r;
      r.chosen_action = act;
      r.status        = err;
      return r;
   endfunction

   assign rd_data  = $signed(mem_rdata);
   assign reward   = $signed(req_ff.value);
   assign last_col = cfg.actions - 4'd1;

   assign s_ok  = {1'b0, req_ff.cur_state} < cfg.states;
   assign sp_ok = {1'b0, req_ff.next_state} < cfg.states;
   assign a_ok  = {1'b0, req_ff.taken_action} < cfg.actions;

   assign explore_now = cfg.learn_enable && (explore_ff > {1'b0, cfg.explore_limit});

   assign lfsr_fb = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];
   assign lfsr_in = {lfsr_fb, lfsr_ff[15:1]};

   // running argmax over the beats coming back from a row scan; first max wins
   assign take        = rd_vld_ff && ((rd_col_ff == 4'd0) || (rd_data > best_val_ff));
   assign best_val_in = take ? rd_data : best_val_ff;
   assign best_idx_in = take ? rd_col_ff : best_idx_ff;

   // new entry: old value plus floor(lr * diff / 2^16), saturated to 32 bits
   assign new_sum = q_ff + $signed(delta_prod_ff[51:16]);

   always_comb begin
      if (!new_sum[36] && (new_sum[35:31] != 5'b00000)) begin
         new_val = 32'h7FFF_FFFF;
      end else if (new_sum[36] && (new_sum[35:31] != 5'b11111)) begin
         new_val = 32'h8000_0000;
      end else begin
         new_val = new_sum[31:0];
      end
   end

   assign mod_start    = (state_ff == S_DECODE) && (req_ff.command == CMD_GET_ACTION) &&
                         s_ok && explore_now;
   assign mod_dividend = lfsr_in;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_addr_ff;
      mem_wdata = '0;
      mem_raddr = entry_addr(row_ff, col_ff);
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
         end
         S_DECODE: begin
            if ((req_ff.command == CMD_LOAD) && s_ok && a_ok) begin
               mem_we    = 1'b1;
               mem_waddr = entry_addr(req_ff.cur_state, {1'b0, req_ff.taken_action});
               mem_wdata = req_ff.value;
            end
         end
         S_DRAIN: begin
            // the last scan beat lands now; fetch the entry being updated
            mem_raddr = entry_addr(req_ff.cur_state, {1'b0, req_ff.taken_action});
         end
         S_WB: begin
            mem_we    = 1'b1;
            mem_waddr = entry_addr(req_ff.cur_state, {1'b0, req_ff.taken_action});
            mem_wdata = new_val;
         end
         default: begin
         end
      endcase
   end

   // free-running update datapath; each register is sampled by the state
   // that follows it
   always_ff @(posedge clock) begin
      best_val_ff   <= best_val_in;
      best_idx_ff   <= best_idx_in;
      rd_col_ff     <= col_ff;
      disc_prod_ff  <= $signed({1'b0, cfg.discount}) * best_val_ff;
      diff_ff       <= reward + $signed(disc_prod_ff[48:16]) - q_ff;
      delta_prod_ff <= $signed({1'b0, cfg.learn_rate}) * diff_ff;
      if (state_ff == S_MUL1) begin
         q_ff <= rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         strobe_ff   <= 1'b0;
         rd_vld_ff   <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         explore_ff  <= '0;
         lfsr_ff     <= LFSR_SEED;
      end else begin
         rd_vld_ff <= (state_ff == S_SCAN);
         case (state_ff)
            S_CLEAR: begin
               strobe_ff   <= 1'b0;
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               strobe_ff <= 1'b0;
               if (start) begin
                  req_ff   <= req_item;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               col_ff <= '0;
               case (req_ff.command)
                  CMD_UPDATE: begin
                     if (s_ok && sp_ok && a_ok) begin
                        strobe_ff <= 1'b0;
                        row_ff    <= req_ff.next_state;
                        state_ff  <= S_SCAN;
                     end else begin
                        rsp_ff    <= make_rsp(3'd0, 1'b1);
                        strobe_ff <= 1'b1;
                        state_ff  <= S_IDLE;
                     end
                  end
                  CMD_GET_ACTION: begin
                     if (!s_ok) begin
                        rsp_ff    <= make_rsp(3'd0, 1'b1);
                        strobe_ff <= 1'b1;
                        state_ff  <= S_IDLE;
                     end else if (explore_now) begin
                        strobe_ff  <= 1'b0;
                        explore_ff <= '0;
                        lfsr_ff    <= lfsr_in;
                        state_ff   <= S_RAND;
                     end else begin
                        strobe_ff <= 1'b0;
                        if (cfg.learn_enable) begin
                           explore_ff <= explore_ff + 17'd1;
                        end
                        row_ff   <= req_ff.cur_state;
                        state_ff <= S_SCAN;
                     end
                  end
                  CMD_LOAD: begin
                     rsp_ff    <= make_rsp(3'd0, !(s_ok && a_ok));
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
                  default: begin
                     rsp_ff    <= make_rsp(3'd0, 1'b1);
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               endcase
            end
            S_SCAN: begin
               strobe_ff <= 1'b0;
               col_ff    <= col_ff + 4'd1;
               if (col_ff == last_col) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (req_ff.command == CMD_UPDATE) begin
                  strobe_ff <= 1'b0;
                  state_ff  <= S_MUL1;
               end else begin
                  rsp_ff    <= make_rsp(best_idx_in[2:0], 1'b0);
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            S_MUL1: begin
               strobe_ff <= 1'b0;
               state_ff  <= S_DIFF;
            end
            S_DIFF: begin
               strobe_ff <= 1'b0;
               state_ff  <= S_MUL2;
            end
            S_MUL2: begin
               strobe_ff <= 1'b0;
               state_ff  <= S_WB;
            end
            S_WB: begin
               rsp_ff    <= make_rsp(3'd0, 1'b0);
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            S_RAND: begin
               if (mod_done) begin
                  rsp_ff    <= make_rsp(mod_remainder[2:0], 1'b0);
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end else begin
                  strobe_ff <= 1'b0;
               end
            end
            default: begin
               strobe_ff <= 1'b0;
               state_ff  <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== rtl/tabular_q_learning_engine.sv =====
// Channel   Handshake               Beat
// req       start high, busy low    req_item: command, states, action, value
// rsp       rsp_strobe, one cycle   rsp_item: chosen_action, status
// csr       csr_write_en            csr_index, csr_wdata
//
// One command at a time. With A the actions in use, an update runs a row
// scan of A table reads, then two multiplies and a write-back; a greedy get
// action runs the scan alone, an exploring one waits on the bit-serial
// remainder. The single table read port sets the scan length. After reset
// a clearing pass zeroes all MAX_STATES*MAX_ACTIONS entries; busy is high
// until it ends. Results cannot be held off; the next command may start in
// the cycle its predecessor's strobe shows.
// Top level: configuration registers, table, remainder unit, engine.
// Uses qle_pkg, qle_table, qle_mod and qle_engine.
`timescale 1ns / 1ps

module tabular_q_learning_engine import qle_pkg::*; #(
   parameter int MAX_STATES  = DEF_MAX_STATES,
   parameter int MAX_ACTIONS = DEF_MAX_ACTIONS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_item,
   output logic                   rsp_strobe,
   output rsp_type                rsp_item,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [6:0]    states_ff;
   logic [3:0]    actions_ff;
   logic [16:0]   lr_ff;
   logic [15:0]   disc_ff;
   logic          learn_en_ff;
   logic [15:0]   limit_ff;
   cfg_type       cfg;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [31:0]   mem_rdata;
   logic          mod_start;
   logic [15:0]   mod_dividend;
   logic          mod_done;
   logic [3:0]    mod_remainder;

   always_ff @(posedge clock) begin
      if (reset) begin
         states_ff   <= RST_STATES_IN_USE;
         actions_ff  <= RST_ACTIONS_IN_USE;
         lr_ff       <= RST_LEARNING_RATE;
         disc_ff     <= RST_DISCOUNT;
         learn_en_ff <= RST_LEARN_ENABLE;
         limit_ff    <= RST_EXPLORE_LIMIT;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_STATES_IN_USE:  states_ff   <= csr_wdata[6:0];
            CSR_ACTIONS_IN_USE: actions_ff  <= csr_wdata[3:0];
            CSR_LEARNING_RATE:  lr_ff       <= csr_wdata[16:0];
            CSR_DISCOUNT:       disc_ff     <= csr_wdata[15:0];
            CSR_LEARN_ENABLE:   learn_en_ff <= csr_wdata[0];
            CSR_EXPLORE_LIMIT:  limit_ff    <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // clamp the raw registers to the ranges the engine works with
   always_comb begin
      if (states_ff == 7'd0) begin
         cfg.states = 7'd1;
      end else if (32'(states_ff) > MAX_STATES) begin
         cfg.states = 7'(MAX_STATES);
      end else begin
         cfg.states = states_ff;
      end
      if (actions_ff == 4'd0) begin
         cfg.actions = 4'd1;
      end else if (32'(actions_ff) > MAX_ACTIONS) begin
         cfg.actions = 4'(MAX_ACTIONS);
      end else begin
         cfg.actions = actions_ff;
      end
      cfg.learn_rate    = (lr_ff > LEARNING_RATE_ONE) ? LEARNING_RATE_ONE : lr_ff;
      cfg.discount      = disc_ff;
      cfg.learn_enable  = learn_en_ff;
      cfg.explore_limit = limit_ff;
   end

   qle_table #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   qle_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (cfg.actions),
      .done      (mod_done),
      .remainder (mod_remainder)
   );

   qle_engine #(
      .MAX_STATES  (MAX_STATES),
      .MAX_ACTIONS (MAX_ACTIONS),
      .DEPTH       (DEPTH),
      .AW          (AW)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_item      (req_item),
      .cfg           (cfg),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata),
      .mod_start     (mod_start),
      .mod_dividend  (mod_dividend),
      .mod_done      (mod_done),
      .mod_remainder (mod_remainder)
   );

endmodule

// ===== rtl/qle_checker.sv =====
// qle_checker: port-level assertions for the Q-learning engine, bound to
// the top level below. Uses qle_pkg.
`timescale 1ns / 1ps

module qle_checker import qle_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input rsp_type rsp_item,
   input logic    rsp_strobe
);

   // a result only closes out a command that was in flight
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a command in flight");

   // the block is free again in the cycle its result shows
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while still busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // a rejected command never reports an action
   a_error_no_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status) |-> (rsp_item.chosen_action == 3'd0))
      else $error("error result carries a nonzero action");

endmodule

bind tabular_q_learning_engine qle_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_item   (rsp_item),
   .rsp_strobe (rsp_strobe)
);
